// ----- rtl/lnp_pkg.sv -----
// Package for the lexicographic next-permutation block.
// Holds the sizes, the item types, the memory request type and the sequencer states.
// No dependencies.
`default_nettype none

package lnp_pkg;

  localparam int MaxElems = 16;
  localparam int ElemBits = 8;
  localparam int IdxBits  = $clog2(MaxElems);
  localparam int LenBits  = $clog2(MaxElems + 1);
  localparam int CfgBits  = 5;
  localparam int CntBits  = 32;

  localparam logic [CfgBits-1:0] LengthReset = CfgBits'(16);
  localparam logic [CntBits-1:0] CountMax    = {CntBits{1'b1}};

  localparam logic OpLoad    = 1'b0;
  localparam logic OpAdvance = 1'b1;

  typedef struct packed {
    logic          operation;
    logic [3:0]    position;
    logic [7:0]    value;
  } in_t;

  typedef struct packed {
    logic [3:0]          position_res;
    logic [7:0]          value_res;
    logic                last;
    logic                exhausted;
    logic [CntBits-1:0]  perm_count;
  } out_t;

  typedef struct packed {
    logic                 we;
    logic [IdxBits-1:0]   waddr;
    logic [ElemBits-1:0]  wdata;
    logic                 re;
    logic [IdxBits-1:0]   raddr;
  } mem_req_t;

  typedef struct packed {
    logic  push;
    out_t  data;
  } emit_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIV_LOAD,
    ST_PIV_CHK,
    ST_SUC_CHK,
    ST_SWAP_W2,
    ST_REV_CHK,
    ST_REV_RD,
    ST_REV_W1,
    ST_REV_W2,
    ST_EMIT,
    ST_EXH
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/lexicographic_next_permutation_top.sv -----
// Top level of the lexicographic next-permutation block.
// A load is written to the element store from the idle state; an advance over len entries
// runs its scans, swap and reversal through the element store before its first result.
// Throughput: one item at a time; results leave at one per cycle in emission unless stalled.
// Reset: length returns to 16 and the count to 1; stored elements stay undefined.
// Depends on lnp_pkg, lnp_mem and lnp_seq.
`default_nettype none

module lexicographic_next_permutation_top
  import lnp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_t                 in_data_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgBits-1:0]  cfg_wdata_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_t                     out_data_o
);

  mem_req_t             mreq;
  emit_t                emit;
  logic [ElemBits-1:0]  rdata;
  logic                 out_ready;
  logic                 out_valid_q;
  out_t                 out_data_q;

  lnp_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mreq),
    .rdata_o (rdata)
  );

  lnp_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready),
    .emit_o      (emit),
    .mreq_o      (mreq),
    .rdata_i     (rdata)
  );

  assign out_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.push) begin
      out_data_q <= emit.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ----- rtl/lnp_mem.sv -----
// Element store: one write port, one read port with registered read data.
// Depends on lnp_pkg for sizes and the request type.
`default_nettype none

module lnp_mem
  import lnp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire mem_req_t             req_i,
  output logic [ElemBits-1:0]       rdata_o
);

  logic [ElemBits-1:0] mem_q [MaxElems];
  logic [ElemBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/lnp_seq.sv -----
// Sequencer: pivot scan, successor scan, swap, tail reversal and emission
// over the element store. Depends on lnp_pkg.
`default_nettype none

module lnp_seq
  import lnp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_t                  in_data_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgBits-1:0]   cfg_wdata_i,
  input  wire logic                 out_ready_i,
  output emit_t                     emit_o,
  output mem_req_t                  mreq_o,
  input  wire logic [ElemBits-1:0]  rdata_i
);

  state_e               state_q, state_d;
  logic [CfgBits-1:0]   length_q;
  logic [LenBits-1:0]   len_q, len_d, len_w;
  logic [IdxBits-1:0]   i_q, i_d, j_q, j_d, k_q, k_d, r_q, r_d, s_q, s_d;
  logic [IdxBits-1:0]   lenm1;
  logic [ElemBits-1:0]  pv_q, pv_d, prev_q, prev_d, tmp_q, tmp_d;
  logic [CntBits-1:0]   count_q, count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      length_q <= LengthReset;
      count_q  <= CntBits'(1);
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        length_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    i_q    <= i_d;
    j_q    <= j_d;
    k_q    <= k_d;
    r_q    <= r_d;
    s_q    <= s_d;
    pv_q   <= pv_d;
    prev_q <= prev_d;
    tmp_q  <= tmp_d;
  end

  always_comb begin
    if (int'(length_q) > MaxElems) begin
      len_w = LenBits'(MaxElems);
    end else begin
      len_w = LenBits'(length_q);
    end
  end

  assign lenm1 = IdxBits'(len_q - LenBits'(1));

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    r_d     = r_q;
    s_d     = s_q;
    pv_d    = pv_q;
    prev_d  = prev_q;
    tmp_d   = tmp_q;
    count_d = count_q;
    mreq_o  = '0;
    emit_o  = '0;
    in_stall_o = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.operation == OpLoad) begin
            if (int'(in_data_i.position) < MaxElems) begin
              mreq_o.we    = 1'b1;
              mreq_o.waddr = IdxBits'(in_data_i.position);
              mreq_o.wdata = ElemBits'(in_data_i.value);
            end
            count_d = CntBits'(1);
          end else begin
            len_d = len_w;
            if (len_w < LenBits'(2)) begin
              state_d = ST_EXH;
            end else begin
              mreq_o.re    = 1'b1;
              mreq_o.raddr = IdxBits'(len_w - LenBits'(1));
              i_d          = IdxBits'(len_w - LenBits'(2));
              state_d      = ST_PIV_LOAD;
            end
          end
        end
      end
      ST_PIV_LOAD: begin
        prev_d       = rdata_i;
        mreq_o.re    = 1'b1;
        mreq_o.raddr = i_q;
        state_d      = ST_PIV_CHK;
      end
      ST_PIV_CHK: begin
        if (rdata_i < prev_q) begin
          j_d          = i_q;
          pv_d         = rdata_i;
          k_d          = lenm1;
          mreq_o.re    = 1'b1;
          mreq_o.raddr = lenm1;
          state_d      = ST_SUC_CHK;
        end else begin
          prev_d = rdata_i;
          if (i_q == '0) begin
            state_d = ST_EXH;
          end else begin
            i_d          = i_q - IdxBits'(1);
            mreq_o.re    = 1'b1;
            mreq_o.raddr = i_q - IdxBits'(1);
          end
        end
      end
      ST_SUC_CHK: begin
        if (rdata_i > pv_q) begin
          mreq_o.we    = 1'b1;
          mreq_o.waddr = j_q;
          mreq_o.wdata = rdata_i;
          state_d      = ST_SWAP_W2;
        end else begin
          k_d          = k_q - IdxBits'(1);
          mreq_o.re    = 1'b1;
          mreq_o.raddr = k_q - IdxBits'(1);
        end
      end
      ST_SWAP_W2: begin
        mreq_o.we    = 1'b1;
        mreq_o.waddr = k_q;
        mreq_o.wdata = pv_q;
        r_d          = lenm1;
        s_d          = j_q + IdxBits'(1);
        if (count_q != CountMax) begin
          count_d = count_q + CntBits'(1);
        end
        state_d = ST_REV_CHK;
      end
      ST_REV_CHK: begin
        mreq_o.re = 1'b1;
        if (r_q > s_q) begin
          mreq_o.raddr = r_q;
          state_d      = ST_REV_RD;
        end else begin
          mreq_o.raddr = '0;
          i_d          = '0;
          state_d      = ST_EMIT;
        end
      end
      ST_REV_RD: begin
        tmp_d        = rdata_i;
        mreq_o.re    = 1'b1;
        mreq_o.raddr = s_q;
        state_d      = ST_REV_W1;
      end
      ST_REV_W1: begin
        mreq_o.we    = 1'b1;
        mreq_o.waddr = r_q;
        mreq_o.wdata = rdata_i;
        state_d      = ST_REV_W2;
      end
      ST_REV_W2: begin
        mreq_o.we    = 1'b1;
        mreq_o.waddr = s_q;
        mreq_o.wdata = tmp_q;
        r_d          = r_q - IdxBits'(1);
        s_d          = s_q + IdxBits'(1);
        state_d      = ST_REV_CHK;
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          emit_o.push              = 1'b1;
          emit_o.data.position_res = 4'(i_q);
          emit_o.data.value_res    = 8'(rdata_i);
          emit_o.data.last         = (i_q == lenm1);
          emit_o.data.exhausted    = 1'b0;
          emit_o.data.perm_count   = count_q;
          if (i_q == lenm1) begin
            state_d = ST_IDLE;
          end else begin
            i_d          = i_q + IdxBits'(1);
            mreq_o.re    = 1'b1;
            mreq_o.raddr = i_q + IdxBits'(1);
          end
        end
      end
      ST_EXH: begin
        if (out_ready_i) begin
          emit_o.push              = 1'b1;
          emit_o.data.position_res = '0;
          emit_o.data.value_res    = '0;
          emit_o.data.last         = 1'b1;
          emit_o.data.exhausted    = 1'b1;
          emit_o.data.perm_count   = count_q;
          state_d                  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- tb/tb_lexicographic_next_permutation_top.sv -----
// Testbench for lexicographic_next_permutation_top: a directed item list, then random
// load/advance sequences under several length settings with random idling on both sides.
// Depends on lnp_pkg and the RTL of the block; predicts every result with a tracker class.
`timescale 1ns / 100ps

class arrangement_tracker;
  logic [lnp_pkg::ElemBits-1:0] elems [lnp_pkg::MaxElems];
  logic [lnp_pkg::CntBits-1:0]  seen;
  logic [lnp_pkg::CfgBits-1:0]  length;
  lnp_pkg::out_t                pending_entries [$];
  int                           errors;

  function new();
    foreach (elems[i]) elems[i] = '0;
    seen    = 1;
    length  = lnp_pkg::LengthReset;
    errors  = 0;
  endfunction

  function void swap_elems(int x, int y);
    logic [lnp_pkg::ElemBits-1:0] t;
    t        = elems[x];
    elems[x] = elems[y];
    elems[y] = t;
  endfunction

  // Step the arrangement and queue the entries it emits.
  function void advance_arrangement();
    int            n;
    int            j;
    int            k;
    int            r;
    int            s;
    lnp_pkg::out_t e;
    n = (length > lnp_pkg::MaxElems) ? lnp_pkg::MaxElems : int'(length);
    j = n - 2;
    while (j >= 0 && !(elems[j] < elems[j+1])) j--;
    if (j < 0) begin
      e.position_res = '0;
      e.value_res    = '0;
      e.last         = 1'b1;
      e.exhausted    = 1'b1;
      e.perm_count   = seen;
      pending_entries.push_back(e);
      return;
    end
    k = n - 1;
    while (k > j && !(elems[k] > elems[j])) k--;
    swap_elems(j, k);
    r = n - 1;
    s = j + 1;
    while (r > s) begin
      swap_elems(r, s);
      r--;
      s++;
    end
    if (seen != lnp_pkg::CountMax) seen++;
    for (int i = 0; i < n; i++) begin
      e.position_res = 4'(i);
      e.value_res    = elems[i];
      e.last         = (i == n - 1);
      e.exhausted    = 1'b0;
      e.perm_count   = seen;
      pending_entries.push_back(e);
    end
  endfunction

  function void take_item(lnp_pkg::in_t it);
    if (it.operation == lnp_pkg::OpLoad) begin
      elems[it.position] = it.value;
      seen = 1;
    end else begin
      advance_arrangement();
    end
  endfunction

  function void match_entry(lnp_pkg::out_t got);
    lnp_pkg::out_t want;
    if (pending_entries.size() == 0) begin
      $error("unexpected result: position_res %0d value_res %0d", got.position_res,
             got.value_res);
      errors++;
      return;
    end
    want = pending_entries.pop_front();
    if (got.position_res !== want.position_res) begin
      $error("position_res mismatch: expected %0d, actual %0d", want.position_res,
             got.position_res);
      errors++;
    end
    if (got.value_res !== want.value_res) begin
      $error("value_res mismatch: expected %0d, actual %0d", want.value_res, got.value_res);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last mismatch: expected %0d, actual %0d", want.last, got.last);
      errors++;
    end
    if (got.exhausted !== want.exhausted) begin
      $error("exhausted mismatch: expected %0d, actual %0d", want.exhausted, got.exhausted);
      errors++;
    end
    if (got.perm_count !== want.perm_count) begin
      $error("perm_count mismatch: expected %0d, actual %0d", want.perm_count,
             got.perm_count);
      errors++;
    end
  endfunction
endclass

module tb_lexicographic_next_permutation_top;
  import lnp_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int SettleCycles = 120;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall_o;
  in_t                in_data;
  logic               cfg_we;
  logic [CfgBits-1:0] cfg_wdata;
  logic               out_valid_o;
  logic               out_stall;
  out_t               out_data_o;

  arrangement_tracker tracker;
  int                 cycles = 0;
  int                 burst_left = 0;
  int                 stall_tick = 0;

  lexicographic_next_permutation_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) tracker.take_item(in_data);
      if (out_valid_o && !out_stall) tracker.match_entry(out_data_o);
    end
  end

  // Rotate the receiver through free-running, light, heavy and periodic stalls.
  always @(negedge clk_i) begin
    stall_tick++;
    case ((stall_tick / 200) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_tick % 16) < 5);
    endcase
  end

  function automatic in_t make_item(logic op, logic [3:0] pos, logic [7:0] val);
    in_t it;
    it.operation = op;
    it.position  = pos;
    it.value     = val;
    return it;
  endfunction

  task automatic send_item(in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic send_advance();
    send_item(make_item(OpAdvance, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255))));
  endtask

  task automatic write_length(logic [CfgBits-1:0] len_val);
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (tracker.pending_entries.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= len_val;
    tracker.length = len_val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    burst_left = 0;
  endtask

  // Fresh array loads followed by advances, with stray loads and partial reloads mixed in.
  task automatic run_phase(logic [CfgBits-1:0] len_val, int budget);
    int n;
    int sent;
    int seq;
    int vmax;
    int upto;
    int adv;
    write_length(len_val);
    n    = (len_val > MaxElems) ? MaxElems : int'(len_val);
    sent = 0;
    seq  = 0;
    while (sent < budget) begin
      vmax = ($urandom_range(0, 2) == 0) ? 3 : 255;
      upto = (seq > 0 && $urandom_range(0, 7) == 0) ? $urandom_range(0, n) : n;
      for (int p = 0; p < upto; p++) begin
        send_item(make_item(OpLoad, 4'(p), 8'($urandom_range(0, vmax))));
        sent++;
      end
      if ($urandom_range(0, 5) == 0) begin
        send_item(make_item(OpLoad, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255))));
        sent++;
      end
      adv = $urandom_range(1, 8);
      repeat (adv) send_advance();
      sent += adv;
      seq++;
    end
  endtask

  initial begin
    logic [CfgBits-1:0] phase_len [11];
    tracker   = new();
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    out_stall = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    write_length(5'd3);
    send_item(make_item(OpLoad, 4'd0, 8'd0));
    send_item(make_item(OpLoad, 4'd1, 8'd255));
    send_item(make_item(OpLoad, 4'd2, 8'd255));
    repeat (3) send_advance();
    send_item(make_item(OpLoad, 4'd15, 8'hAA));
    send_advance();
    send_item(make_item(OpLoad, 4'd0, 8'd1));
    send_item(make_item(OpLoad, 4'd1, 8'd2));
    send_item(make_item(OpLoad, 4'd2, 8'd128));
    repeat (6) send_advance();
    send_item(make_item(OpLoad, 4'd2, 8'd127));
    repeat (2) send_advance();

    phase_len = '{5'd16, 5'd5, 5'd1, 5'd31, 5'd8, 5'd0, 5'd2, 5'd17, 5'd4,
                  5'($urandom_range(2, 16)), 5'($urandom_range(2, 16))};
    foreach (phase_len[i]) run_phase(phase_len[i], 14);

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (tracker.pending_entries.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- lexicographic_next_permutation_top.f -----
rtl/lnp_pkg.sv
rtl/lnp_mem.sv
rtl/lnp_seq.sv
rtl/lexicographic_next_permutation_top.sv
tb/tb_lexicographic_next_permutation_top.sv
